### hdl/smap_pkg.sv
package smap_pkg;

  // Quantities are Q(32-FRAC_BITS).FRAC_BITS, fractions and decays are Q1.15.
  localparam int FRAC_BITS = 16;
  localparam int Q15_BITS  = 15;

  // Divider retires two quotient bits per cycle over a 64-bit dividend.
  localparam int DIV_BITS     = 64;
  localparam int DIV_RADIX    = 2;
  localparam int DIV_CYCLES   = DIV_BITS / DIV_RADIX;
  localparam int DIV_CNT_W    = $clog2(DIV_CYCLES);

  // Item kinds carried on the input selector.
  localparam logic [2:0] FN_DAY       = 3'd0;
  localparam logic [2:0] FN_LOAD_SOIL = 3'd1;
  localparam logic [2:0] FN_LOAD_SURF = 3'd2;
  localparam logic [2:0] FN_LOAD_SEC  = 3'd3;
  localparam logic [2:0] FN_LOAD_GW   = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] CFG_SOIL_CAP  = 3'd0;
  localparam logic [2:0] CFG_FIELD_CAP = 3'd1;
  localparam logic [2:0] CFG_WILTING   = 3'd2;
  localparam logic [2:0] CFG_FRACTIONS = 3'd3;
  localparam logic [2:0] CFG_LEVELS    = 3'd4;
  localparam logic [2:0] CFG_SURF_DEC  = 3'd5;
  localparam logic [2:0] CFG_BASE_DEC  = 3'd6;
  localparam logic [2:0] CFG_SCALE     = 3'd7;

  typedef struct packed {
    logic [31:0] soil_capacity;
    logic [31:0] field_capacity_level;
    logic [31:0] wilting_level;
    logic [31:0] rate_fractions;
    logic [63:0] reservoir_levels;
    logic [47:0] surface_decays;
    logic [31:0] base_decays;
    logic [31:0] flow_scale;
  } cfg_t;

  typedef struct packed {
    logic [31:0] total_flow;
    logic [31:0] soil_storage_out;
    logic [31:0] surface_storage_out;
    logic [30:0] second_storage_out;
    logic [31:0] groundwater_storage_out;
    logic [30:0] surface_runoff;
    logic [30:0] actual_evaporation;
    logic [30:0] recharge;
    logic [31:0] direct_flow_one;
    logic [31:0] lateral_flow;
    logic [31:0] direct_flow_two;
    logic [31:0] base_flow;
  } res_t;

  // Datapath operations. M_* loads the shared multiplier, W_* stores its result.
  typedef enum logic [5:0] {
    OP_NONE, OP_ACCEPT, OP_CAP, OP_TU, OP_M_AI, OP_W_AI, OP_D, OP_SQ, OP_ES_DIV,
    OP_ES, OP_AVAIL, OP_M_ER, OP_W_ER, OP_M_R1, OP_W_R1, OP_M_R2, OP_W_R2,
    OP_M_MG, OP_W_MG, OP_M_ED, OP_W_ED, OP_M_E2, OP_W_E2, OP_M_E3, OP_W_E3,
    OP_M_EB, OP_W_EB, OP_M_Q1, OP_W_Q1, OP_M_QP, OP_W_QP, OP_M_Q2, OP_W_Q2,
    OP_M_QB, OP_W_QB, OP_UPD, OP_COMMIT
  } op_t;

  typedef struct packed {
    logic div_done;
    logic out_busy;
  } sts_t;

  localparam int          PC_W    = 6;
  localparam logic [5:0]  PC_LAST = 6'd33;

  // Step program of one day item.
  function automatic op_t prog_op(input logic [PC_W-1:0] pc);
    op_t op;
    unique case (pc)
      6'd0:  op = OP_CAP;
      6'd1:  op = OP_TU;
      6'd2:  op = OP_M_AI;
      6'd3:  op = OP_W_AI;
      6'd4:  op = OP_D;
      6'd5:  op = OP_SQ;
      6'd6:  op = OP_ES_DIV;
      6'd7:  op = OP_ES;
      6'd8:  op = OP_AVAIL;
      6'd9:  op = OP_M_ER;
      6'd10: op = OP_W_ER;
      6'd11: op = OP_M_R1;
      6'd12: op = OP_W_R1;
      6'd13: op = OP_M_R2;
      6'd14: op = OP_W_R2;
      6'd15: op = OP_M_MG;
      6'd16: op = OP_W_MG;
      6'd17: op = OP_M_ED;
      6'd18: op = OP_W_ED;
      6'd19: op = OP_M_E2;
      6'd20: op = OP_W_E2;
      6'd21: op = OP_M_E3;
      6'd22: op = OP_W_E3;
      6'd23: op = OP_M_EB;
      6'd24: op = OP_W_EB;
      6'd25: op = OP_M_Q1;
      6'd26: op = OP_W_Q1;
      6'd27: op = OP_M_QP;
      6'd28: op = OP_W_QP;
      6'd29: op = OP_M_Q2;
      6'd30: op = OP_W_Q2;
      6'd31: op = OP_M_QB;
      6'd32: op = OP_W_QB;
      6'd33: op = OP_UPD;
      default: op = OP_NONE;
    endcase
    return op;
  endfunction

endpackage

### hdl/smap_daily_runoff_step.sv
// Daily SMAP rainfall-runoff step in Q16.16 fixed point.
// Input beats arrive on the in_ channel. in_tuser selects the kind of item:
// a day step, or a load of the soil, surface, second surface or groundwater
// storage from the load_value field. A load updates its storage in the cycle
// the beat is taken and produces no result. A day step produces one result
// beat on the out_ channel carrying the total flow, the four new storages and
// the flow components. Configuration registers are written on the cfg_
// channel, which is always ready, and must only be written while idle.
// From acceptance until its result is registered, a day step runs 34
// sequencer steps through one shared 32x32 multiplier, two divisions on the
// radix-4 divider (soil wetness and surface runoff), and one commit step.
// The next item can be accepted on the cycle after the commit, so a new day
// item is not taken before the last one has committed; load items are
// accepted back to back.
// The result sits in an output register; when the receiver stalls, the
// block still accepts and computes the following day item and holds it at
// the commit step until the pending result beat is taken.
// Reset (rst_n low, synchronous) clears the four storages to zero, returns
// the registers to their defaults (soil capacity 1.0) and drops out_tvalid.
module smap_daily_runoff_step
  import smap_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  // Input channel.
  input  logic         in_tvalid,
  output logic         in_tready,
  // precipitation [31:0], evapotranspiration [63:32], margin_evaporation [95:64],
  // load_value [127:96]
  input  logic [127:0] in_tdata,
  // func [2:0]
  input  logic [2:0]   in_tuser,
  // Result channel.
  output logic         out_tvalid,
  input  logic         out_tready,
  // total_flow [31:0], soil_storage_out [63:32], surface_storage_out [95:64],
  // second_storage_out [126:96], groundwater_storage_out [158:127],
  // surface_runoff [189:159], actual_evaporation [220:190], recharge [251:221],
  // direct_flow_one [283:252], lateral_flow [315:284], direct_flow_two [347:316],
  // base_flow [379:348], zero fill [383:380]
  output logic [383:0] out_tdata,
  // Configuration write channel.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  cfg_t cfg_r;
  op_t  cmd;
  sts_t sts;
  res_t res;

  // Register file; every index maps to a register, so all writes land.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.soil_capacity        <= 32'd65536;
      cfg_r.field_capacity_level <= '0;
      cfg_r.wilting_level        <= '0;
      cfg_r.rate_fractions       <= '0;
      cfg_r.reservoir_levels     <= '0;
      cfg_r.surface_decays       <= '0;
      cfg_r.base_decays          <= '0;
      cfg_r.flow_scale           <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SOIL_CAP:  cfg_r.soil_capacity        <= cfg_data[31:0];
        CFG_FIELD_CAP: cfg_r.field_capacity_level <= cfg_data[31:0];
        CFG_WILTING:   cfg_r.wilting_level        <= cfg_data[31:0];
        CFG_FRACTIONS: cfg_r.rate_fractions       <= cfg_data[31:0];
        CFG_LEVELS:    cfg_r.reservoir_levels     <= cfg_data;
        CFG_SURF_DEC:  cfg_r.surface_decays       <= cfg_data[47:0];
        CFG_BASE_DEC:  cfg_r.base_decays          <= cfg_data[31:0];
        CFG_SCALE:     cfg_r.flow_scale           <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  smap_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_is_day (in_tuser == FN_DAY),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  smap_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg       (cfg_r),
    .in_func   (in_tuser),
    .in_p      (in_tdata[31:0]),
    .in_et     (in_tdata[63:32]),
    .in_em     (in_tdata[95:64]),
    .in_lv     (in_tdata[127:96]),
    .res       (res),
    .out_valid (out_tvalid),
    .out_ready (out_tready)
  );

  // Pack the result beat, first field in the low bits.
  assign out_tdata = {4'b0, res.base_flow, res.direct_flow_two, res.lateral_flow,
                      res.direct_flow_one, res.recharge, res.actual_evaporation,
                      res.surface_runoff, res.groundwater_storage_out,
                      res.second_storage_out, res.surface_storage_out,
                      res.soil_storage_out, res.total_flow};

endmodule

### hdl/smap_div.sv
module smap_div
  import smap_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DIV_BITS-1:0] num,
  input  logic [31:0]         den,
  output logic [DIV_BITS-1:0] quo,
  output logic                done
);

  logic [DIV_BITS-1:0]  q_r, q_nxt;
  logic [31:0]          rem_r, rem_nxt;
  logic [31:0]          den_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r, done_r;
  logic [32:0]          trial;

  // Restoring division, two quotient bits per cycle.
  always_comb begin
    rem_nxt = rem_r;
    q_nxt   = q_r;
    trial   = '0;
    for (int i = 0; i < DIV_RADIX; i++) begin
      trial = {rem_nxt, q_nxt[DIV_BITS-1]};
      q_nxt = {q_nxt[DIV_BITS-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt  = 32'(trial - {1'b0, den_r});
        q_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == DIV_CNT_W'(DIV_CYCLES - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_CYCLES - 1)) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quo  = q_r;
  assign done = done_r;

endmodule

### hdl/smap_dp.sv
module smap_dp
  import smap_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  op_t         cmd,
  output sts_t        sts,
  input  cfg_t        cfg,
  input  logic [2:0]  in_func,
  input  logic [31:0] in_p,
  input  logic [31:0] in_et,
  input  logic [31:0] in_em,
  input  logic [31:0] in_lv,
  output res_t        res,
  output logic        out_valid,
  input  logic        out_ready
);

  localparam logic signed [37:0] MAX38 = 38'sd2147483647;
  localparam logic signed [37:0] MIN38 = -38'sd2147483648;
  localparam logic signed [31:0] MAX32 = 32'sh7fffffff;
  localparam logic [63:0]        RND_Q = 64'd1 << (FRAC_BITS - 1);
  localparam logic [63:0]        RND_F = 64'd1 << (Q15_BITS - 1);

  function automatic logic signed [37:0] sx(input logic [31:0] v);
    return {{6{v[31]}}, v};
  endfunction

  function automatic logic signed [37:0] ux(input logic [30:0] v);
    return {7'b0, v};
  endfunction

  function automatic logic [30:0] u31(input logic [31:0] v);
    return v[31] ? 31'h7fffffff : v[30:0];
  endfunction

  function automatic logic [31:0] sat32(input logic signed [37:0] x);
    if (x > MAX38) return 32'h7fffffff;
    else if (x < MIN38) return 32'h80000000;
    else return x[31:0];
  endfunction

  function automatic logic [31:0] clampnn(input logic signed [37:0] x);
    if (x < 0) return 32'd0;
    else if (x > MAX38) return 32'h7fffffff;
    else return x[31:0];
  endfunction

  function automatic logic [31:0] mag(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // Storages and latched inputs.
  logic [31:0] soil_r, surf_r, sec_r, gw_r;
  logic [30:0] p_r, et_r, em_r;
  // Intermediates.
  logic [31:0] cap_r, tu_r, ai_r, d_r, es_r, avail_r, er_r, t1_r, rec_r;
  logic [31:0] marg_r, ed_r, ed2_r, ed3_r, eb_r, q1_r, qp_r, q2_r, qb_r, total_r;
  logic signed [37:0] den_r, w_r;
  logic        pgt_r, den_pos_r;
  logic [63:0] prod_r;
  logic        neg_r, sh16_r;
  res_t        res_r;
  logic        out_valid_r;

  logic [30:0] str, capc, pmur, h1, h, scale;
  assign str   = u31(cfg.soil_capacity);
  assign capc  = u31(cfg.field_capacity_level);
  assign pmur  = u31(cfg.wilting_level);
  assign h1    = u31(cfg.reservoir_levels[31:0]);
  assign h     = u31(cfg.reservoir_levels[63:32]);
  assign scale = u31(cfg.flow_scale);

  // Shared multiplier operand selection.
  logic [31:0] a_op, b_op, lim, ex2;
  logic        sh16, mul_load;
  always_comb begin
    lim = sat32(sx(surf_r) - sx(marg_r));
    if (sx(lim) > ux(h)) lim = {1'b0, h};
    ex2 = sat32(sx(surf_r) - ux(h) - sx(marg_r));
    if (ex2[31]) ex2 = '0;
    a_op     = '0;
    b_op     = '0;
    sh16     = 1'b0;
    mul_load = 1'b1;
    case (cmd)
      OP_M_AI: begin a_op = cap_r;  b_op = {16'b0, cfg.rate_fractions[31:16]}; end
      OP_SQ:   begin a_op = d_r;    b_op = d_r; end
      OP_M_ER: begin
        a_op = sat32(ux(et_r) - sx(avail_r)); b_op = tu_r; sh16 = 1'b1;
      end
      OP_M_R1: begin a_op = tu_r;   b_op = {16'b0, cfg.rate_fractions[15:0]}; end
      OP_M_R2: begin
        a_op = t1_r; b_op = sat32(sx(soil_r) - ux(capc)); sh16 = 1'b1;
      end
      OP_M_MG: begin
        a_op = sat32(sx(surf_r) - ux(h1)); b_op = {16'b0, cfg.surface_decays[15:0]};
      end
      OP_M_ED: begin a_op = lim;    b_op = {16'b0, cfg.surface_decays[31:16]}; end
      OP_M_E2: begin a_op = ex2;    b_op = {16'b0, cfg.surface_decays[47:32]}; end
      OP_M_E3: begin a_op = sec_r;  b_op = {16'b0, cfg.base_decays[15:0]}; end
      OP_M_EB: begin a_op = gw_r;   b_op = {16'b0, cfg.base_decays[31:16]}; end
      OP_M_Q1: begin a_op = ed_r;   b_op = {1'b0, scale}; sh16 = 1'b1; end
      OP_M_QP: begin a_op = ed3_r;  b_op = {1'b0, scale}; sh16 = 1'b1; end
      OP_M_Q2: begin a_op = ed2_r;  b_op = {1'b0, scale}; sh16 = 1'b1; end
      OP_M_QB: begin a_op = eb_r;   b_op = {1'b0, scale}; sh16 = 1'b1; end
      default: mul_load = 1'b0;
    endcase
  end

  // Rounded, shifted and saturated product.
  logic [63:0] rnd;
  logic [32:0] pm;
  logic [31:0] mres;
  always_comb begin
    rnd = sh16_r ? ((prod_r + RND_Q) >> FRAC_BITS) : ((prod_r + RND_F) >> Q15_BITS);
    pm  = (rnd > 64'h80000000) ? 33'h080000000 : rnd[32:0];
    if (neg_r) mres = 32'(~pm + 33'd1);
    else if (pm > 33'h07fffffff) mres = MAX32;
    else mres = pm[31:0];
  end

  // Divider.
  logic        div_start, div_done;
  logic [63:0] div_num, div_quo;
  logic [31:0] div_den;
  assign div_start = (cmd == OP_CAP) || (cmd == OP_ES_DIV);
  always_comb begin
    if (cmd == OP_CAP) begin
      div_num = 64'(mag(soil_r)) << FRAC_BITS;
      div_den = (str == '0) ? 32'd1 : {1'b0, str};
    end else begin
      div_num = prod_r;
      div_den = den_pos_r ? den_r[31:0] : 32'd1;
    end
  end

  smap_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .done  (div_done)
  );

  logic [32:0] qc;
  logic [31:0] tu_val, es_div;
  logic signed [37:0] spill, d_den;
  always_comb begin
    qc     = (div_quo > 64'h80000000) ? 33'h080000000 : div_quo[32:0];
    if (soil_r[31]) tu_val = 32'(~qc + 33'd1);
    else if (qc > 33'h07fffffff) tu_val = MAX32;
    else tu_val = qc[31:0];
    es_div = (div_quo > 64'h7fffffff) ? MAX32 : div_quo[31:0];
    spill  = (w_r > ux(str)) ? (w_r - ux(str)) : 38'sd0;
    d_den  = sx(d_r) + sx(cap_r);
  end

  // Control state: storages and result handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      soil_r      <= '0;
      surf_r      <= '0;
      sec_r       <= '0;
      gw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd == OP_ACCEPT) begin
        case (in_func)
          FN_LOAD_SOIL: soil_r <= in_lv;
          FN_LOAD_SURF: surf_r <= in_lv;
          FN_LOAD_SEC:  sec_r  <= in_lv;
          FN_LOAD_GW:   gw_r   <= in_lv;
          default: ;
        endcase
      end
      if (cmd == OP_COMMIT) begin
        soil_r      <= sat32((w_r < ux(str)) ? w_r : ux(str));
        surf_r      <= sat32(sx(surf_r) + sx(es_r) - sx(marg_r) - sx(ed_r) - sx(ed2_r)
                             + spill);
        sec_r       <= clampnn(sx(sec_r) + sx(marg_r) - sx(ed3_r) - ux(em_r));
        gw_r        <= sat32(sx(gw_r) + sx(rec_r) - sx(eb_r));
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (mul_load) begin
      prod_r <= 64'(mag(a_op)) * 64'(mag(b_op));
      neg_r  <= a_op[31] ^ b_op[31];
      sh16_r <= sh16;
    end
    case (cmd)
      OP_ACCEPT: begin
        p_r  <= u31(in_p);
        et_r <= u31(in_et);
        em_r <= u31(in_em);
      end
      OP_CAP:   cap_r <= sat32(ux(str) - sx(soil_r));
      OP_TU:    tu_r  <= tu_val;
      OP_W_AI:  ai_r  <= mres;
      OP_D: begin
        d_r   <= sat32(ux(p_r) - sx(ai_r));
        pgt_r <= ux(p_r) > sx(ai_r);
      end
      OP_SQ: begin
        den_r     <= d_den;
        den_pos_r <= d_den > 0;
      end
      OP_ES:    es_r    <= pgt_r ? (den_pos_r ? es_div : clampnn(sx(d_r))) : '0;
      OP_AVAIL: avail_r <= sat32(ux(p_r) - sx(es_r));
      OP_W_ER: begin
        if (sx(soil_r) > ux(pmur))
          er_r <= (sx(avail_r) > ux(et_r)) ? {1'b0, et_r}
                                           : clampnn(sx(avail_r) + sx(mres));
        else
          er_r <= '0;
      end
      OP_W_R1:  t1_r   <= mres;
      OP_W_R2:  rec_r  <= (sx(soil_r) > ux(capc)) ? clampnn(sx(mres)) : '0;
      OP_W_MG:  marg_r <= (sx(surf_r) > ux(h1)) ? mres : '0;
      OP_W_ED:  ed_r   <= mres;
      OP_W_E2:  ed2_r  <= mres;
      OP_W_E3:  ed3_r  <= mres;
      OP_W_EB:  eb_r   <= mres;
      OP_W_Q1:  q1_r   <= mres;
      OP_W_QP:  qp_r   <= mres;
      OP_W_Q2:  q2_r   <= mres;
      OP_W_QB:  qb_r   <= mres;
      OP_UPD: begin
        w_r     <= sx(soil_r) + ux(p_r) - sx(es_r) - sx(er_r) - sx(rec_r);
        total_r <= sat32(sx(q1_r) + sx(qp_r) + sx(q2_r) + sx(qb_r));
      end
      OP_COMMIT: begin
        res_r.total_flow              <= total_r;
        res_r.soil_storage_out        <= sat32((w_r < ux(str)) ? w_r : ux(str));
        res_r.surface_storage_out     <= sat32(sx(surf_r) + sx(es_r) - sx(marg_r)
                                               - sx(ed_r) - sx(ed2_r) + spill);
        res_r.second_storage_out      <= 31'(clampnn(sx(sec_r) + sx(marg_r) - sx(ed3_r)
                                                     - ux(em_r)));
        res_r.groundwater_storage_out <= sat32(sx(gw_r) + sx(rec_r) - sx(eb_r));
        res_r.surface_runoff          <= es_r[30:0];
        res_r.actual_evaporation      <= er_r[30:0];
        res_r.recharge                <= rec_r[30:0];
        res_r.direct_flow_one         <= q1_r;
        res_r.lateral_flow            <= qp_r;
        res_r.direct_flow_two         <= q2_r;
        res_r.base_flow               <= qb_r;
      end
      default: ;
    endcase
  end

  assign sts.div_done = div_done;
  assign sts.out_busy = out_valid_r && !out_ready;
  assign res          = res_r;
  assign out_valid    = out_valid_r;

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == OP_COMMIT) |-> !(out_valid_r && !out_ready))
    else $error("result committed over a beat not yet taken");

  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == OP_COMMIT) |=> out_valid_r)
    else $error("committed result not presented");

  a_sec_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == OP_COMMIT) |=> !sec_r[31])
    else $error("second storage negative after a day step");

  a_soil_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == OP_COMMIT) |=> (sx(soil_r) <= ux(str)))
    else $error("soil storage above capacity after a day step");

endmodule

### hdl/smap_ctrl.sv
module smap_ctrl
  import smap_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  input  logic in_is_day,
  output logic in_tready,
  input  sts_t sts,
  output op_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_RUN    = 4'b0010,
    ST_WAIT   = 4'b0100,
    ST_COMMIT = 4'b1000
  } state_t;

  state_t          state_r, state_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  op_t             step;

  assign step = prog_op(pc_r);

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    cmd       = OP_NONE;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd = OP_ACCEPT;
          if (in_is_day) begin
            pc_nxt    = '0;
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        cmd = step;
        if (step == OP_CAP || step == OP_ES_DIV) state_nxt = ST_WAIT;
        else if (pc_r == PC_LAST) state_nxt = ST_COMMIT;
        else pc_nxt = pc_r + 1'b1;
      end
      ST_WAIT: begin
        if (sts.div_done) begin
          pc_nxt    = pc_r + 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_COMMIT: begin
        if (!sts.out_busy) begin
          cmd       = OP_COMMIT;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end

endmodule
